### sv/edfp_pkg.sv
// Package for the drift feedforward predictor: constants, types and clamp helpers.
`default_nettype none

package edfp_pkg;

  localparam int ACC_W = 37;
  localparam int OPD_W = 18;
  localparam int RND_W = ACC_W - 15;

  localparam logic [15:0] ONE_Q = 16'd32768;
  localparam logic [15:0] FF_LIMIT = 16'd1311;
  localparam logic [15:0] DRIFT_STABLE = 16'd655;
  localparam logic [15:0] GAIN_FLOOR = 16'd655;
  localparam logic [15:0] GAIN_RESET = 16'd19661;
  localparam logic signed [16:0] FB_THRESHOLD = 17'sd1966;
  localparam logic [2:0] STABLE_STEPS = 3'd4;

  localparam logic signed [OPD_W-1:0] K_EMA = 18'sd5898;
  localparam logic signed [OPD_W-1:0] K_DRIFT = 18'sd9830;
  localparam logic signed [OPD_W-1:0] K_DRIFT_KEEP = 18'sd22938;
  localparam logic signed [OPD_W-1:0] K_MAE = 18'sd4915;
  localparam logic signed [OPD_W-1:0] K_MAE_KEEP = 18'sd27853;
  localparam logic signed [OPD_W-1:0] GAIN_DECAY = 18'sd32113;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_START_GAIN = 1'b1;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_FEEDBACK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAVG,
    ST_DAVG,
    ST_DRIFT_A,
    ST_DRIFT_B,
    ST_PRED,
    ST_GAIN_MUL,
    ST_FF_MUL,
    ST_ERR_A,
    ST_ERR_B,
    ST_STABLE,
    ST_FB_MUL,
    ST_FB_DONE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic                    clear;
    logic signed [OPD_W-1:0] a;
    logic signed [OPD_W-1:0] b;
  } mac_op_t;

  function automatic logic [15:0] clamp_in(input logic signed [16:0] v);
    logic [15:0] r;
    if (v < 17'sd0) begin
      r = 16'd0;
    end else if (v > 17'sd32768) begin
      r = ONE_Q;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_unit(input logic signed [RND_W-1:0] v);
    logic [15:0] r;
    if (v < 0) begin
      r = 16'd0;
    end else if (v > RND_W'(32768)) begin
      r = ONE_Q;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [16:0] clamp_sym(input logic signed [RND_W-1:0] v);
    logic signed [16:0] r;
    if (v < -RND_W'(32768)) begin
      r = -17'sd32768;
    end else if (v > RND_W'(32768)) begin
      r = 17'sd32768;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  function automatic logic signed [OPD_W-1:0] clamp_ff(input logic signed [RND_W-1:0] v);
    logic signed [OPD_W-1:0] r;
    if (v < -RND_W'(1311)) begin
      r = -18'sd1311;
    end else if (v > RND_W'(1311)) begin
      r = 18'sd1311;
    end else begin
      r = v[OPD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/edfp_mac.sv
// Shared signed multiply-accumulate unit with Q7.15 round-half-up output.
`default_nettype none

module edfp_mac (
  input  wire                               clk,
  input  edfp_pkg::mac_op_t                 op,
  output logic signed [edfp_pkg::RND_W-1:0] rnd
);
  import edfp_pkg::*;

  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [2*OPD_W-1:0] prod;
  logic signed [ACC_W-1:0]   biased;

  assign prod = op.a * op.b;

  always_comb begin
    acc_nxt = (op.clear ? '0 : acc_r) + {{(ACC_W-2*OPD_W){prod[2*OPD_W-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign biased = acc_r + ACC_W'(16384);
  assign rnd = biased[ACC_W-1:15];

endmodule

`default_nettype wire

### sv/ema_drift_feedforward_predictor.sv
// Top level of the drift feedforward predictor: sequencer, state and output register.
//
// Usage: items arrive on the in_ channel (valid/stall) and each gives exactly one
// result on the out_ channel (valid/stall). cmd 0 is a prediction step, cmd 1 a
// gain feedback item. The cfg_ port writes enable and start_gain at any idle time.
// One multiplier-accumulator is shared by all products under a small sequencer,
// so an item is taken only while the sequencer is idle. A prediction step runs
// CAVG through STABLE before FIN, a feedback item that decays the gain FB_MUL and
// FB_DONE, and an ignored or skipped item goes straight to FIN; the next item can
// be accepted in the cycle after the result is loaded into the output register.
// The length of a step is set by its eight products through the shared unit.
// Reset clears the averages, the stable count and the enable, and loads the gain
// with 0.6. When the receiver stalls, the result holds in the output register; the
// block still accepts and works on one more item, then waits until the slot frees.
`default_nettype none

module ema_drift_feedforward_predictor (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_cmd,
  input  wire signed [16:0]  in_coherence,
  input  wire signed [16:0]  in_delay_level,
  input  wire signed [16:0]  in_influence,
  input  wire signed [16:0]  in_feedback_delta,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [11:0] out_feedforward,
  output logic [15:0]        out_prediction,
  output logic signed [16:0] out_drift_level,
  output logic [15:0]        out_mean_abs_error,
  output logic [15:0]        out_working_gain,
  output logic               out_snapshot,
  input  wire                cfg_we,
  input  wire                cfg_index,
  input  wire [15:0]         cfg_wdata
);
  import edfp_pkg::*;

  state_t state_r, state_nxt;

  logic              enable_r, enable_nxt;
  logic              seeded_r, seeded_nxt;
  logic [15:0]       cavg_r, cavg_nxt;
  logic [15:0]       davg_r, davg_nxt;
  logic signed [16:0] drift_r, drift_nxt;
  logic [15:0]       eavg_r, eavg_nxt;
  logic [15:0]       pred_r, pred_nxt;
  logic [2:0]        run_r, run_nxt;
  logic [15:0]       gain_r, gain_nxt;

  logic [15:0]       coh_r, coh_nxt;
  logic [15:0]       dly_r, dly_nxt;
  logic [15:0]       infl_r, infl_nxt;
  logic signed [OPD_W-1:0] err_r, err_nxt;
  logic signed [11:0] ff_r, ff_nxt;
  logic              snap_r, snap_nxt;

  logic              ov_r, ov_nxt;
  logic signed [11:0] o_ff_r;
  logic [15:0]       o_pred_r;
  logic signed [16:0] o_drift_r;
  logic [15:0]       o_eavg_r;
  logic [15:0]       o_gain_r;
  logic              o_snap_r;

  mac_op_t                 mac_op;
  logic signed [RND_W-1:0] rnd;

  logic [15:0]       coh_c, dly_c, infl_c;
  logic              accept, load_out;
  logic signed [16:0] drift_new;
  logic [15:0]       pred_new, eavg_new, gain_dec;
  logic [15:0]       adrift;
  logic [2:0]        run_inc;
  logic signed [OPD_W-1:0] abs_err;

  edfp_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .rnd (rnd)
  );

  assign coh_c  = clamp_in(in_coherence);
  assign dly_c  = clamp_in(in_delay_level);
  assign infl_c = clamp_in(in_influence);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == ST_FIN) && (!ov_r || !out_stall);

  assign drift_new = clamp_sym(rnd);
  assign pred_new  = clamp_unit(RND_W'(cavg_r) + RND_W'(drift_new));
  assign eavg_new  = clamp_unit(rnd);
  assign gain_dec  = (clamp_unit(rnd) < GAIN_FLOOR) ? GAIN_FLOOR : clamp_unit(rnd);
  assign adrift    = drift_r[16] ? 16'(-drift_r) : drift_r[15:0];
  assign abs_err   = err_r[OPD_W-1] ? -err_r : err_r;
  assign run_inc   = run_r + 3'd1;

  always_comb begin
    state_nxt  = state_r;
    enable_nxt = enable_r;
    seeded_nxt = seeded_r;
    cavg_nxt   = cavg_r;
    davg_nxt   = davg_r;
    drift_nxt  = drift_r;
    eavg_nxt   = eavg_r;
    pred_nxt   = pred_r;
    run_nxt    = run_r;
    gain_nxt   = gain_r;
    coh_nxt    = coh_r;
    dly_nxt    = dly_r;
    infl_nxt   = infl_r;
    err_nxt    = err_r;
    ff_nxt     = ff_r;
    snap_nxt   = snap_r;
    mac_op     = '{clear: 1'b0, a: '0, b: '0};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          coh_nxt  = coh_c;
          dly_nxt  = dly_c;
          infl_nxt = infl_c;
          ff_nxt   = '0;
          snap_nxt = 1'b0;
          state_nxt = ST_FIN;
          if (enable_r && in_cmd == CMD_STEP && infl_c != 16'd0) begin
            state_nxt = ST_CAVG;
            if (!seeded_r) begin
              seeded_nxt = 1'b1;
              cavg_nxt   = coh_c;
              davg_nxt   = dly_c;
              drift_nxt  = '0;
              eavg_nxt   = '0;
              pred_nxt   = coh_c;
            end
          end else if (enable_r && in_cmd == CMD_FEEDBACK &&
                       in_feedback_delta > FB_THRESHOLD) begin
            state_nxt = ST_FB_MUL;
          end
        end
      end
      ST_CAVG: begin
        mac_op    = '{clear: 1'b1, a: K_EMA, b: OPD_W'(coh_r) - OPD_W'(cavg_r)};
        state_nxt = ST_DAVG;
      end
      ST_DAVG: begin
        cavg_nxt  = clamp_unit(RND_W'(cavg_r) + rnd);
        mac_op    = '{clear: 1'b1, a: K_EMA, b: OPD_W'(dly_r) - OPD_W'(davg_r)};
        state_nxt = ST_DRIFT_A;
      end
      ST_DRIFT_A: begin
        davg_nxt  = clamp_unit(RND_W'(davg_r) + rnd);
        mac_op    = '{clear: 1'b1, a: K_DRIFT_KEEP, b: OPD_W'(drift_r)};
        state_nxt = ST_DRIFT_B;
      end
      ST_DRIFT_B: begin
        mac_op    = '{clear: 1'b0, a: K_DRIFT, b: OPD_W'(cavg_r) - OPD_W'(davg_r)};
        state_nxt = ST_PRED;
      end
      ST_PRED: begin
        drift_nxt = drift_new;
        pred_nxt  = pred_new;
        err_nxt   = OPD_W'(pred_new) - OPD_W'(coh_r);
        state_nxt = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        mac_op    = '{clear: 1'b1, a: OPD_W'(gain_r), b: err_r};
        state_nxt = ST_FF_MUL;
      end
      ST_FF_MUL: begin
        mac_op    = '{clear: 1'b1, a: clamp_ff(rnd), b: OPD_W'(infl_r)};
        state_nxt = ST_ERR_A;
      end
      ST_ERR_A: begin
        ff_nxt    = rnd[11:0];
        mac_op    = '{clear: 1'b1, a: K_MAE_KEEP, b: OPD_W'(eavg_r)};
        state_nxt = ST_ERR_B;
      end
      ST_ERR_B: begin
        mac_op    = '{clear: 1'b0, a: K_MAE, b: abs_err};
        state_nxt = ST_STABLE;
      end
      ST_STABLE: begin
        eavg_nxt = eavg_new;
        if (eavg_new < FF_LIMIT && adrift < DRIFT_STABLE) begin
          if (run_inc >= STABLE_STEPS) begin
            snap_nxt = 1'b1;
            run_nxt  = '0;
          end else begin
            run_nxt = run_inc;
          end
        end else begin
          run_nxt = '0;
        end
        state_nxt = ST_FIN;
      end
      ST_FB_MUL: begin
        mac_op    = '{clear: 1'b1, a: OPD_W'(gain_r), b: GAIN_DECAY};
        state_nxt = ST_FB_DONE;
      end
      ST_FB_DONE: begin
        gain_nxt  = gain_dec;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:     enable_nxt = cfg_wdata[0];
        REG_START_GAIN: gain_nxt = (cfg_wdata > ONE_Q) ? ONE_Q : cfg_wdata;
        default:        enable_nxt = enable_r;
      endcase
    end
  end

  assign ov_nxt = load_out || (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      enable_r <= 1'b0;
      seeded_r <= 1'b0;
      cavg_r   <= '0;
      davg_r   <= '0;
      drift_r  <= '0;
      eavg_r   <= '0;
      pred_r   <= '0;
      run_r    <= '0;
      gain_r   <= GAIN_RESET;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      enable_r <= enable_nxt;
      seeded_r <= seeded_nxt;
      cavg_r   <= cavg_nxt;
      davg_r   <= davg_nxt;
      drift_r  <= drift_nxt;
      eavg_r   <= eavg_nxt;
      pred_r   <= pred_nxt;
      run_r    <= run_nxt;
      gain_r   <= gain_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coh_r  <= coh_nxt;
    dly_r  <= dly_nxt;
    infl_r <= infl_nxt;
    err_r  <= err_nxt;
    ff_r   <= ff_nxt;
    snap_r <= snap_nxt;
    if (load_out) begin
      o_ff_r    <= ff_r;
      o_pred_r  <= pred_r;
      o_drift_r <= drift_r;
      o_eavg_r  <= eavg_r;
      o_gain_r  <= gain_r;
      o_snap_r  <= snap_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_feedforward    = o_ff_r;
  assign out_prediction     = o_pred_r;
  assign out_drift_level    = o_drift_r;
  assign out_mean_abs_error = o_eavg_r;
  assign out_working_gain   = o_gain_r;
  assign out_snapshot       = o_snap_r;

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && ov_r && out_stall) |=> (state_r == ST_FIN))
    else $error("sequencer left the finish state while the output slot was full");

  a_ff_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (out_feedforward <= 12'sd1311 && out_feedforward >= -12'sd1311))
    else $error("feedforward outside its limit");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= ONE_Q)
    else $error("working gain above one");

  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < STABLE_STEPS)
    else $error("stable count not cleared at the snapshot");

  a_drift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (drift_r <= 17'sd32768 && drift_r >= -17'sd32768 && pred_r <= ONE_Q))
    else $error("drift or prediction outside range");

endmodule

`default_nettype wire
